// File: src/assert_macros.svh
// assertion macros for the rtl files, included by bpcw_core
// expects aclk and aresetn in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge, off while in reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
    else $error(msg);

// plain condition that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
    else $error(msg);

`endif

// File: src/bpcw_pkg.sv
// shared types, constants and bit-step functions for the crc24 / whitening block
// no dependencies
package bpcw_pkg;

    localparam int CHAN_W     = 6;
    localparam int LFSR_W     = 7;
    localparam int CRC_W      = 24;
    localparam int BYTE_W     = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CRC_W-1:0]  CRC_INIT   = 24'hAAAAAA;
    localparam logic [CRC_W-1:0]  CRC_TAPS   = 24'h5A6000;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 6'd37;

    // crc bytes that follow the last pdu byte, counted down
    localparam logic [1:0] CRC_CNT_IDLE = 2'd0;
    localparam logic [1:0] CRC_CNT_LAST = 2'd1;
    localparam logic [1:0] CRC_CNT_MID  = 2'd2;
    localparam logic [1:0] CRC_CNT_LOW  = 2'd3;

    // register byte address index (paddr[2])
    localparam logic REG_CHANNEL = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [LFSR_W-1:0] lfsr;
    } whiten_res_t;

    function automatic logic [LFSR_W-1:0] lfsr_seed(input logic [CHAN_W-1:0] chan);
        return {1'b1, chan};
    endfunction

    // eight crc bit steps, bit 7 first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc_in;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            fb = c[0] ^ b[k];
            c  = {fb, c[CRC_W-1:1]} ^ (fb ? CRC_TAPS : '0);
        end
        return c;
    endfunction

    // eight whitening steps, bit 7 first
    function automatic whiten_res_t whiten_byte(input logic [LFSR_W-1:0] lfsr_in,
                                                input logic [BYTE_W-1:0] b);
        whiten_res_t r;
        logic        lsb;
        r.data = b;
        r.lfsr = lfsr_in;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            lsb       = r.lfsr[0];
            r.data[k] = r.data[k] ^ lsb;
            r.lfsr    = {lsb, r.lfsr[LFSR_W-1:1]};
            r.lfsr[2] = r.lfsr[2] ^ lsb;
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] bit_rev8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int k = 0; k < BYTE_W; k++) begin
            r[BYTE_W-1-k] = v[k];
        end
        return r;
    endfunction

endpackage

// File: src/bpcw_cfg.sv
// apb register file: channel index that seeds the whitening lfsr
// depends on bpcw_pkg
module bpcw_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpcw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bpcw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bpcw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [bpcw_pkg::CHAN_W-1:0]      channel_index
);
    import bpcw_pkg::*;

    logic [CHAN_W-1:0] chan_reg;
    logic [CHAN_W-1:0] chan_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1] == REG_CHANNEL);

    always_comb begin
        chan_next = chan_reg;
        if (wr_en) begin
            chan_next = pwdata[CHAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg <= CHAN_RESET;
        end else begin
            chan_reg <= chan_next;
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1] == REG_CHANNEL)
                    ? {{(APB_DATA_W-CHAN_W){1'b0}}, chan_reg} : '0;
    assign channel_index = chan_reg;

endmodule

// File: src/bpcw_core.sv
// input register, crc24 / whitening byte step and result register
// depends on bpcw_pkg and assert_macros.svh
module bpcw_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [bpcw_pkg::CHAN_W-1:0]  channel_index,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bpcw_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                         s_tuser,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bpcw_pkg::BYTE_W-1:0]  m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);
    import bpcw_pkg::*;
    `include "assert_macros.svh"

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_first_reg, in_last_reg;

    // running state
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [1:0]        cnt_reg, cnt_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic              out_crc_reg, out_crc_next;
    logic              out_eop_reg, out_eop_next;

    logic              accept, out_load, advance, emit_crc;
    logic [CRC_W-1:0]  crc_start;
    logic [LFSR_W-1:0] lfsr_start;
    logic [BYTE_W-1:0] crc_sel;
    whiten_res_t       wd, wc;

    assign out_load = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (cnt_reg == CRC_CNT_IDLE) && out_load;
    assign emit_crc = (cnt_reg != CRC_CNT_IDLE) && out_load;
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_data_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // data byte path
    assign crc_start  = in_first_reg ? CRC_INIT : crc_reg;
    assign lfsr_start = in_first_reg ? lfsr_seed(channel_index) : lfsr_reg;
    assign wd         = whiten_byte(lfsr_start, in_data_reg);

    // crc byte path, low byte first
    always_comb begin
        unique case (cnt_reg)
            CRC_CNT_LOW:  crc_sel = crc_reg[7:0];
            CRC_CNT_MID:  crc_sel = crc_reg[15:8];
            CRC_CNT_LAST: crc_sel = crc_reg[23:16];
            default:      crc_sel = '0;
        endcase
    end
    assign wc = whiten_byte(lfsr_reg, bit_rev8(crc_sel));

    always_comb begin
        crc_next       = crc_reg;
        lfsr_next      = lfsr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_crc_next   = out_crc_reg;
        out_eop_next   = out_eop_reg;
        if (out_load) begin
            out_valid_next = advance || emit_crc;
        end
        if (advance) begin
            crc_next      = crc_byte(crc_start, in_data_reg);
            lfsr_next     = wd.lfsr;
            cnt_next      = in_last_reg ? CRC_CNT_LOW : CRC_CNT_IDLE;
            out_data_next = wd.data;
            out_crc_next  = 1'b0;
            out_eop_next  = 1'b0;
        end else if (emit_crc) begin
            lfsr_next     = wc.lfsr;
            cnt_next      = cnt_reg - 2'd1;
            out_data_next = wc.data;
            out_crc_next  = 1'b1;
            out_eop_next  = (cnt_reg == CRC_CNT_LAST);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_INIT;
            lfsr_reg      <= lfsr_seed(CHAN_RESET);
            cnt_reg       <= CRC_CNT_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            crc_reg       <= crc_next;
            lfsr_reg      <= lfsr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_crc_reg  <= out_crc_next;
        out_eop_reg  <= out_eop_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_crc_reg;
    assign m_tlast  = out_eop_reg;

    `ASSERT_CLK(a_crc_hold, (cnt_reg != CRC_CNT_IDLE) |=> $stable(crc_reg),
                "crc changed while its bytes were being sent")
    `ASSERT_CLK(a_no_take_in_crc, (cnt_reg != CRC_CNT_IDLE && in_valid_reg) |-> !s_tready,
                "input taken while crc bytes pending")
    `ASSERT_CLK(a_eop_on_last, (cnt_reg == CRC_CNT_LAST && out_load) |=> (m_tvalid && m_tlast),
                "third crc byte not marked end of packet")
    `ASSERT_ALWAYS(a_eop_is_crc, !(out_valid_reg && out_eop_reg) || out_crc_reg,
                   "end of packet on a non-crc byte")

endmodule

// File: src/ble_pdu_crc24_whitener.sv
// top level: ble advertising pdu crc24 generator and data whitener
// depends on bpcw_pkg, bpcw_cfg and bpcw_core
//
// usage
//   s_ stream carries pdu bytes in stored bit order, bit 7 handled first;
//   s_tuser marks the first byte of a pdu (crc restarts at 0xaaaaaa and the
//   whitening lfsr is reseeded from the channel), s_tlast marks the last one
//   m_ stream returns one whitened byte per pdu byte; after the last byte three
//   whitened, bit-reversed crc bytes follow (low, middle, high) with m_tuser
//   high, and m_tlast high on the third of them
//   apb port holds the channel index (reset 37) at byte address 0; a write takes
//   effect at the next first-marked byte; the user must write it only while the
//   block idles, as the block itself does not enforce this
// data path
//   a request goes input register -> result register; one byte per cycle is
//   sustained while m_tready is high, except that after a last-marked byte the
//   three crc bytes are sent first and the input register holds its next byte
// reset and stall
//   synchronous active-low reset empties both registers, loads the crc with
//   0xaaaaaa and the lfsr with the reset channel; with m_tready low the result
//   holds and one more request is still taken into the input register
module ble_pdu_crc24_whitener (
    input  logic                             aclk,
    input  logic                             aresetn,
    // apb configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpcw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bpcw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bpcw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // pdu byte input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] pdu_byte
    input  logic [0:0]                       s_tuser,   // [0] first_byte
    input  logic                             s_tlast,   // last_byte
    // whitened byte output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic [0:0]                       m_tuser,   // [0] is_crc
    output logic                             m_tlast    // end_of_packet
);
    import bpcw_pkg::*;

    logic [CHAN_W-1:0] channel_index;

    bpcw_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .channel_index (channel_index)
    );

    bpcw_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .channel_index (channel_index),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser[0]),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser[0]),
        .m_tlast       (m_tlast)
    );

endmodule
